// ----- sv/apic_pkg.sv -----
`timescale 1ns / 1ps

package apic_pkg;

  localparam int FILTER_ORDER_DEF = 6;
  localparam int MAX_ORDER        = 8;
  localparam int NUM_COEF         = 6;

  // register indexes on the configuration port
  localparam int REG_COEF_FIRST = 0;
  localparam int REG_STRUCTURE  = 6;
  localparam int CFG_IDX_W      = 3;

  localparam int COEF_W   = 24;
  localparam int HIST_W   = 32;
  localparam int SAMPLE_W = 24;
  localparam int CSHIFT   = 22;
  localparam int PROD_W   = COEF_W + HIST_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int RND_W    = ACC_W - CSHIFT;

  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [HIST_W-1:0]   hist_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef struct packed {
    hist_t val;
    logic  hit;
  } sat_t;

  typedef struct packed {
    sample_t val;
    logic    hit;
  } sat24_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_CAPB,
    S_D_M0,
    S_D_M1,
    S_D_ACC,
    S_D_WR,
    S_T_ADD,
    S_T_M1,
    S_T_M0,
    S_T_W1,
    S_T_W0,
    S_OUT
  } state_t;

  localparam hist_t HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
  localparam hist_t HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};

  // round Q.22 to Q.0 (ties up), then clamp to 32 bits
  function automatic sat_t round_sat(input acc_t a);
    acc_t                    t;
    logic [RND_W-1:0]        s;
    logic [RND_W-HIST_W:0]   top;
    sat_t                    r;
    t   = a + (acc_t'(1) <<< (CSHIFT - 1));
    s   = t[ACC_W-1:CSHIFT];
    top = s[RND_W-1:HIST_W-1];
    r.hit = !((&top) || (~|top));
    if (r.hit) begin
      r.val = s[RND_W-1] ? HIST_MIN : HIST_MAX;
    end else begin
      r.val = s[HIST_W-1:0];
    end
    return r;
  endfunction

  function automatic sat_t add_sat(input hist_t a, input hist_t b);
    logic [HIST_W:0] s;
    sat_t            r;
    s = {a[HIST_W-1], a} + {b[HIST_W-1], b};
    r.hit = s[HIST_W] ^ s[HIST_W-1];
    if (r.hit) begin
      r.val = s[HIST_W] ? HIST_MIN : HIST_MAX;
    end else begin
      r.val = s[HIST_W-1:0];
    end
    return r;
  endfunction

  function automatic sat24_t sat_out(input hist_t a);
    logic [HIST_W-SAMPLE_W:0] top;
    sat24_t                   r;
    top   = a[HIST_W-1:SAMPLE_W-1];
    r.hit = !((&top) || (~|top));
    if (r.hit) begin
      r.val = a[HIST_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      r.val = a[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/apic_ram.sv -----
`timescale 1ns / 1ps

module apic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 6,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/all_pole_iir_cascade_core.sv -----
`timescale 1ns / 1ps

// channel   signals                                dir  beat
// input     in_valid / in_ready, sample_in         in   one sample
// output    out_valid / out_ready, sample_out,     out  one filtered sample
//           clipped
// config    cfg_write, cfg_index, cfg_data         in   one register write
//
// One sample at a time through a single 24x32 multiplier and the history RAM.
// Each sample walks the sections in turn, through the direct or the transposed
// section states; sections = ceil(FILTER_ORDER/2), so three at order 6.
// The output register frees the result side; a held result delays the next
// sample only if its result is ready before the previous one is taken.
// Reset clears coefficients and structure select; history valid bits make
// every history entry read as zero until written, so no clearing pass.

module all_pole_iir_cascade_core #(
  parameter int FILTER_ORDER = apic_pkg::FILTER_ORDER_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [apic_pkg::SAMPLE_W-1:0] sample_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [apic_pkg::SAMPLE_W-1:0] sample_out,
  output logic                             clipped,
  input  logic                             cfg_write,
  input  logic [apic_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [apic_pkg::COEF_W-1:0]      cfg_data
);

  localparam int ORD = (FILTER_ORDER < 1) ? 1 :
                       ((FILTER_ORDER > apic_pkg::MAX_ORDER) ? apic_pkg::MAX_ORDER :
                        FILTER_ORDER);
  localparam int AW  = (ORD > 1) ? $clog2(ORD) : 1;
  localparam int BW  = $clog2(ORD + 2);

  apic_pkg::state_t state, state_next;

  logic [BW-1:0]     base;
  apic_pkg::hist_t   v, ha, hb, rdata_m;
  apic_pkg::prod_t   prod, mul_p;
  apic_pkg::acc_t    acc;
  logic              clip;
  logic              rd_vld;
  logic [ORD-1:0]    hist_vld;
  apic_pkg::coef_t   coef [apic_pkg::NUM_COEF];
  logic              structure;

  apic_pkg::coef_t   c_old, c_new, mul_c;
  apic_pkg::hist_t   mul_x;
  logic              single, last_sec, out_load;
  logic [AW-1:0]     addr_old, addr_new;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  apic_pkg::hist_t   ram_wdata;
  logic [apic_pkg::HIST_W-1:0] ram_rdata;

  apic_pkg::sat_t    rs, as;
  apic_pkg::sat24_t  os;

  apic_ram #(
    .WIDTH (apic_pkg::HIST_W),
    .DEPTH (ORD)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // odd order: last section is first order, uses only the entry at base
  assign single   = (ORD % 2 == 1) && (int'(base) == ORD - 1);
  assign last_sec = (int'(base) + 2 >= ORD);
  assign addr_old = base[AW-1:0];
  assign addr_new = single ? base[AW-1:0] : AW'(base + 1'b1);

  always_comb begin
    c_old = '0;
    c_new = '0;
    for (int k = 0; k < apic_pkg::NUM_COEF; k++) begin
      if (!single && int'(base) == k) c_old = coef[k];
      if (int'(addr_new) == k) c_new = coef[k];
    end
  end

  assign rdata_m = rd_vld ? apic_pkg::hist_t'(ram_rdata) : '0;
  assign mul_p   = mul_c * mul_x;
  assign rs      = apic_pkg::round_sat(acc);
  assign as      = apic_pkg::add_sat(v, hb);
  assign os      = apic_pkg::sat_out(v);

  always_comb begin
    state_next = state;
    unique case (state)
      apic_pkg::S_IDLE:  if (in_valid) state_next = apic_pkg::S_RDA;
      apic_pkg::S_RDA:   state_next = apic_pkg::S_RDB;
      apic_pkg::S_RDB:   state_next = apic_pkg::S_CAPB;
      apic_pkg::S_CAPB:  state_next = structure ? apic_pkg::S_T_ADD : apic_pkg::S_D_M0;
      apic_pkg::S_D_M0:  state_next = apic_pkg::S_D_M1;
      apic_pkg::S_D_M1:  state_next = apic_pkg::S_D_ACC;
      apic_pkg::S_D_ACC: state_next = apic_pkg::S_D_WR;
      apic_pkg::S_D_WR:  state_next = last_sec ? apic_pkg::S_OUT : apic_pkg::S_RDA;
      apic_pkg::S_T_ADD: state_next = apic_pkg::S_T_M1;
      apic_pkg::S_T_M1:  state_next = apic_pkg::S_T_M0;
      apic_pkg::S_T_M0:  state_next = apic_pkg::S_T_W1;
      apic_pkg::S_T_W1:  state_next = apic_pkg::S_T_W0;
      apic_pkg::S_T_W0:  state_next = last_sec ? apic_pkg::S_OUT : apic_pkg::S_RDA;
      apic_pkg::S_OUT:   if (!out_valid || out_ready) state_next = apic_pkg::S_IDLE;
      default:           state_next = apic_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    ram_raddr = addr_old;
    ram_we    = 1'b0;
    ram_waddr = addr_new;
    ram_wdata = rs.val;
    mul_c     = c_old;
    mul_x     = ha;
    unique case (state)
      apic_pkg::S_IDLE:  in_ready = 1'b1;
      apic_pkg::S_RDB:   ram_raddr = addr_new;
      apic_pkg::S_D_M1: begin
        mul_c = c_new;
        mul_x = hb;
      end
      apic_pkg::S_D_ACC: begin
        ram_we    = !single;
        ram_waddr = addr_old;
        ram_wdata = hb;
      end
      apic_pkg::S_D_WR:  ram_we = 1'b1;
      apic_pkg::S_T_M1: begin
        mul_c = c_new;
        mul_x = v;
      end
      apic_pkg::S_T_M0:  mul_x = v;
      apic_pkg::S_T_W1:  ram_we = 1'b1;
      apic_pkg::S_T_W0: begin
        ram_we    = !single;
        ram_waddr = addr_old;
      end
      apic_pkg::S_OUT:   out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= apic_pkg::S_IDLE;
      out_valid <= 1'b0;
      hist_vld  <= '0;
      structure <= 1'b0;
      for (int k = 0; k < apic_pkg::NUM_COEF; k++) coef[k] <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ram_we) hist_vld[ram_waddr] <= 1'b1;
      if (cfg_write) begin
        for (int k = 0; k < apic_pkg::NUM_COEF; k++) begin
          if (int'(cfg_index) == apic_pkg::REG_COEF_FIRST + k) coef[k] <= cfg_data;
        end
        if (int'(cfg_index) == apic_pkg::REG_STRUCTURE) structure <= cfg_data[0];
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rd_vld <= hist_vld[ram_raddr];
    prod   <= mul_p;
    unique case (state)
      apic_pkg::S_IDLE: begin
        v    <= apic_pkg::hist_t'(sample_in);
        base <= '0;
        clip <= 1'b0;
      end
      apic_pkg::S_RDB:   ha <= single ? '0 : rdata_m;
      apic_pkg::S_CAPB:  hb <= rdata_m;
      apic_pkg::S_D_M0:  acc <= apic_pkg::acc_t'(v) <<< apic_pkg::CSHIFT;
      apic_pkg::S_D_M1:  acc <= acc - apic_pkg::acc_t'(prod);
      apic_pkg::S_D_ACC: acc <= acc - apic_pkg::acc_t'(prod);
      apic_pkg::S_D_WR: begin
        v    <= rs.val;
        clip <= clip | rs.hit;
        base <= BW'(base + 2'd2);
      end
      apic_pkg::S_T_ADD: begin
        v    <= as.val;
        clip <= clip | as.hit;
      end
      apic_pkg::S_T_M1:  acc <= apic_pkg::acc_t'(ha) <<< apic_pkg::CSHIFT;
      apic_pkg::S_T_M0:  acc <= acc - apic_pkg::acc_t'(prod);
      apic_pkg::S_T_W1: begin
        clip <= clip | rs.hit;
        acc  <= -apic_pkg::acc_t'(prod);
      end
      apic_pkg::S_T_W0: begin
        clip <= clip | (rs.hit & !single);
        base <= BW'(base + 2'd2);
      end
      apic_pkg::S_OUT: begin
        if (out_load) begin
          sample_out <= os.val;
          clipped    <= clip | os.hit;
        end
      end
      default: ;
    endcase
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == apic_pkg::S_RDA && base == '0)
    else $error("sample accepted but section walk did not start at zero");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> int'(ram_waddr) < ORD)
    else $error("history write beyond filter order");

  a_base_range: assert property (@(posedge clk) disable iff (rst)
    state != apic_pkg::S_IDLE && state != apic_pkg::S_OUT |-> int'(base) < ORD)
    else $error("section index out of range during walk");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    state == apic_pkg::S_OUT && (!out_valid || out_ready)
      |=> out_valid && state == apic_pkg::S_IDLE)
    else $error("finished sample not presented on output");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int FILTER_ORDER = apic_pkg::FILTER_ORDER_DEF;
  localparam int ORDER = (FILTER_ORDER < 1) ? 1 :
                         ((FILTER_ORDER > apic_pkg::MAX_ORDER) ? apic_pkg::MAX_ORDER :
                          FILTER_ORDER);
  localparam int REG_UNUSED   = apic_pkg::REG_STRUCTURE + 1;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 700;
  localparam longint OUT_MAX  = 64'sd8388607;
  localparam longint OUT_MIN  = -64'sd8388608;

  typedef logic [apic_pkg::COEF_W-1:0] cfg_word_t;

  typedef struct {
    apic_pkg::sample_t val;
    logic              clip;
  } filt_out_t;

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_ready;
  apic_pkg::sample_t                sample_in;
  logic                             out_valid;
  logic                             out_ready;
  apic_pkg::sample_t                sample_out;
  logic                             clipped;
  logic                             cfg_write;
  logic [apic_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [apic_pkg::COEF_W-1:0]      cfg_data;

  // filter state mirrored on the predictor side
  apic_pkg::coef_t fb_coef [apic_pkg::MAX_ORDER];
  apic_pkg::hist_t hist_mem [apic_pkg::MAX_ORDER];
  logic            use_transposed;
  filt_out_t       expected_samples [$];

  int  mismatches;
  int  idle_cycles;
  int  samples_sent;
  bit  gaps_on;
  bit  stall_on;

  all_pole_iir_cascade_core #(
    .FILTER_ORDER(FILTER_ORDER)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .clipped    (clipped),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic apic_pkg::hist_t clamp32(input longint v, inout bit hit);
    if (v > longint'(apic_pkg::HIST_MAX)) begin
      hit = 1'b1;
      return apic_pkg::HIST_MAX;
    end
    if (v < longint'(apic_pkg::HIST_MIN)) begin
      hit = 1'b1;
      return apic_pkg::HIST_MIN;
    end
    return apic_pkg::hist_t'(v);
  endfunction

  // Q.22 -> Q.0, ties toward +inf, then clamp
  function automatic apic_pkg::hist_t round_to_hist(input longint acc, inout bit hit);
    return clamp32((acc + (longint'(1) <<< (apic_pkg::CSHIFT - 1))) >>> apic_pkg::CSHIFT,
                   hit);
  endfunction

  function automatic filt_out_t filter_sample(input apic_pkg::sample_t x);
    filt_out_t r;
    longint    v;
    longint    acc;
    bit        hit;
    hit = 1'b0;
    v   = x;
    if (!use_transposed) begin
      for (int i = 0; i + 1 < ORDER; i += 2) begin
        acc = (v <<< apic_pkg::CSHIFT) - longint'(fb_coef[i]) * longint'(hist_mem[i])
              - longint'(fb_coef[i+1]) * longint'(hist_mem[i+1]);
        hist_mem[i]   = hist_mem[i+1];
        hist_mem[i+1] = round_to_hist(acc, hit);
        v = hist_mem[i+1];
      end
      if (ORDER % 2 == 1) begin
        acc = (v <<< apic_pkg::CSHIFT)
              - longint'(fb_coef[ORDER-1]) * longint'(hist_mem[ORDER-1]);
        hist_mem[ORDER-1] = round_to_hist(acc, hit);
        v = hist_mem[ORDER-1];
      end
    end else begin
      for (int i = 0; i + 1 < ORDER; i += 2) begin
        v = clamp32(v + longint'(hist_mem[i+1]), hit);
        hist_mem[i+1] = round_to_hist((longint'(hist_mem[i]) <<< apic_pkg::CSHIFT)
                                      - longint'(fb_coef[i+1]) * v, hit);
        hist_mem[i]   = round_to_hist(-(longint'(fb_coef[i]) * v), hit);
      end
      if (ORDER % 2 == 1) begin
        v = clamp32(v + longint'(hist_mem[ORDER-1]), hit);
        hist_mem[ORDER-1] = round_to_hist(-(longint'(fb_coef[ORDER-1]) * v), hit);
      end
    end
    if (v > OUT_MAX) begin
      v   = OUT_MAX;
      hit = 1'b1;
    end else if (v < OUT_MIN) begin
      v   = OUT_MIN;
      hit = 1'b1;
    end
    r.val  = apic_pkg::sample_t'(v);
    r.clip = hit;
    return r;
  endfunction

  function automatic int pick_gap(input bit enable);
    int r;
    if (!enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  function automatic apic_pkg::sample_t rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return apic_pkg::sample_t'($urandom);
    if (r < 70) return apic_pkg::sample_t'(int'($urandom_range(0, 65535)) - 32768);
    if (r < 82) begin
      return ($urandom_range(0, 1) != 0) ? apic_pkg::sample_t'(OUT_MAX)
                                         : apic_pkg::sample_t'(OUT_MIN);
    end
    if (r < 92) return '0;
    r = 1 << $urandom_range(0, 22);
    return ($urandom_range(0, 1) != 0) ? apic_pkg::sample_t'(r) : apic_pkg::sample_t'(-r);
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    mismatches++;
  endtask

  // all tasks below start and end right after a falling edge
  task automatic send_sample(input apic_pkg::sample_t s);
    int gap;
    in_valid  = 1'b1;
    sample_in = s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid  = 1'b0;
    sample_in = apic_pkg::sample_t'($urandom);
    gap = pick_gap(gaps_on);
    repeat (gap) @(negedge clk);
    samples_sent++;
  endtask

  task automatic wait_drained();
    while (expected_samples.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [apic_pkg::COEF_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx[apic_pkg::CFG_IDX_W-1:0];
    cfg_data  = data;
    @(posedge clk);
    if (idx >= apic_pkg::REG_COEF_FIRST &&
        idx < apic_pkg::REG_COEF_FIRST + apic_pkg::NUM_COEF) begin
      fb_coef[idx - apic_pkg::REG_COEF_FIRST] = apic_pkg::coef_t'(data);
    end else if (idx == apic_pkg::REG_STRUCTURE) begin
      use_transposed = data[0];
    end
    @(negedge clk);
    cfg_write = 1'b0;
    cfg_data  = '0;
  endtask

  task automatic write_coefs(input int c0, input int c1, input int c2,
                             input int c3, input int c4, input int c5);
    write_reg(apic_pkg::REG_COEF_FIRST + 0, c0[apic_pkg::COEF_W-1:0]);
    write_reg(apic_pkg::REG_COEF_FIRST + 1, c1[apic_pkg::COEF_W-1:0]);
    write_reg(apic_pkg::REG_COEF_FIRST + 2, c2[apic_pkg::COEF_W-1:0]);
    write_reg(apic_pkg::REG_COEF_FIRST + 3, c3[apic_pkg::COEF_W-1:0]);
    write_reg(apic_pkg::REG_COEF_FIRST + 4, c4[apic_pkg::COEF_W-1:0]);
    write_reg(apic_pkg::REG_COEF_FIRST + 5, c5[apic_pkg::COEF_W-1:0]);
  endtask

  // zero coefficients after reset: every sample goes straight through
  task automatic run_passthrough();
    send_sample('0);
    send_sample(apic_pkg::sample_t'(OUT_MAX));
    send_sample(apic_pkg::sample_t'(OUT_MIN));
    send_sample(apic_pkg::sample_t'(1));
    send_sample(apic_pkg::sample_t'(-1));
    send_sample(apic_pkg::sample_t'(24'h555555));
    send_sample(apic_pkg::sample_t'(24'hAAAAAA));
  endtask

  // resonant first section, mild second, third made first order (c0 = 0)
  task automatic run_direct_resonator();
    wait_drained();
    write_coefs(3397386, -6710886, 1048576, 2097152, 0, -2097152);
    write_reg(apic_pkg::REG_STRUCTURE, '0);
    send_sample(apic_pkg::sample_t'(4194304));
    send_sample('0);
    send_sample('0);
    send_sample(apic_pkg::sample_t'(-123457));
  endtask

  // coefficient extremes drive the history into the rails
  task automatic run_clipping();
    wait_drained();
    write_coefs(8388607, -8388608, -8388608, -8388608, 8388607, -8388608);
    send_sample(apic_pkg::sample_t'(OUT_MAX));
    send_sample(apic_pkg::sample_t'(OUT_MIN));
    send_sample(apic_pkg::sample_t'(OUT_MAX));
  endtask

  // history left from the clipping run is kept across the switch
  task automatic run_transposed_switch();
    wait_drained();
    write_coefs(3397386, -6710886, 1048576, 2097152, 0, -2097152);
    write_reg(apic_pkg::REG_STRUCTURE, cfg_word_t'(1));
    send_sample(apic_pkg::sample_t'(4194304));
    send_sample('0);
    send_sample(apic_pkg::sample_t'(OUT_MIN));
    send_sample('0);
  endtask

  task automatic run_direct_switch_back();
    wait_drained();
    write_reg(apic_pkg::REG_STRUCTURE, '0);
    send_sample(apic_pkg::sample_t'(1000));
    send_sample('0);
  endtask

  // index past the last register must not disturb anything
  task automatic run_unused_register();
    wait_drained();
    write_reg(REG_UNUSED, '1);
    send_sample(apic_pkg::sample_t'(-4194304));
    send_sample(apic_pkg::sample_t'(77));
  endtask

  task automatic set_random_section(input int k, input int style);
    int c0;
    int c1;
    int bound;
    int r;
    if (style < 6) begin
      // stable pair: |c0| < 0.8, |c1| <= 0.9 * (1 + c0)
      c0    = int'($urandom_range(0, 2 * 3355443)) - 3355443;
      bound = (((1 << apic_pkg::CSHIFT) + c0) / 10) * 9;
      c1    = int'($urandom_range(0, 2 * bound)) - bound;
    end else if (style < 8) begin
      c0 = int'(apic_pkg::coef_t'($urandom));
      c1 = int'(apic_pkg::coef_t'($urandom));
    end else begin
      r  = $urandom_range(0, 4);
      c0 = (r == 0) ? 8388607 : (r == 1) ? -8388608 : (r == 2) ? 1 : (r == 3) ? -1 : 0;
      r  = $urandom_range(0, 4);
      c1 = (r == 0) ? 8388607 : (r == 1) ? -8388608 : (r == 2) ? 4194304 :
           (r == 3) ? -4194304 : 0;
    end
    if ($urandom_range(0, 3) == 0) c0 = 0;
    write_reg(apic_pkg::REG_COEF_FIRST + 2 * k, c0[apic_pkg::COEF_W-1:0]);
    write_reg(apic_pkg::REG_COEF_FIRST + 2 * k + 1, c1[apic_pkg::COEF_W-1:0]);
  endtask

  task automatic run_random_phases();
    int start;
    int count;
    int style;
    start = samples_sent;
    while (samples_sent - start < RANDOM_ITEMS) begin
      wait_drained();
      style = $urandom_range(0, 9);
      for (int k = 0; k < apic_pkg::NUM_COEF / 2; k++) set_random_section(k, style);
      write_reg(apic_pkg::REG_STRUCTURE, cfg_word_t'($urandom_range(0, 1)));
      if ($urandom_range(0, 4) == 0) write_reg(REG_UNUSED, cfg_word_t'($urandom));
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      count = $urandom_range(20, 80);
      repeat (count) begin
        send_sample(rand_sample());
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    sample_in = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    mismatches   = 0;
    samples_sent = 0;
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    use_transposed = 1'b0;
    for (int i = 0; i < apic_pkg::MAX_ORDER; i++) begin
      fb_coef[i]  = '0;
      hist_mem[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_passthrough();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    run_direct_resonator();
    run_clipping();
    run_transposed_switch();
    run_direct_switch_back();
    run_unused_register();
    run_random_phases();

    wait_drained();
    repeat (40) @(posedge clk);
    if (expected_samples.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_samples.size()));
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result side back-pressure: short holds mostly, now and then a long one
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        hold = pick_gap(1'b1);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      expected_samples.push_back(filter_sample(sample_in));
    end
  end

  always @(posedge clk) begin
    filt_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing pending", sample_out));
      end else begin
        want = expected_samples.pop_front();
        if (sample_out !== want.val) begin
          report_mismatch($sformatf("sample_out %0d, want %0d", sample_out, want.val));
        end
        if (clipped !== want.clip) begin
          report_mismatch($sformatf("clipped %b, want %b (sample %0d)",
                                    clipped, want.clip, want.val));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

// ----- files.f -----
sv/apic_pkg.sv
sv/apic_ram.sv
sv/all_pole_iir_cascade_core.sv
test/testbench.sv
